// ===== rtl/sfrb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfrb_pkg
// shared types, widths, register codes and arithmetic helpers of the row blur
// ----------------------------------------------------------------------------
package sfrb_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int WEIGHT_W  = 16;
    localparam int ROWNUM_W  = 12;
    localparam int COL_W     = 13;
    localparam int RADIUS_W  = 5;
    localparam int BANK_W    = 64;
    localparam int BANK_N    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = 48;
    localparam int LANES     = 4;

    localparam int MAX_RADIUS_DEF = 16;
    localparam int ROW_MAX_DEF    = 4096;
    localparam int CHANNELS_DEF   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTEND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W0_3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W4_7    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W8_11   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W12_15  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_W16     = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] chan0;
        logic signed [SAMPLE_W-1:0] chan1;
        logic signed [SAMPLE_W-1:0] chan2;
        logic signed [SAMPLE_W-1:0] chan3;
        logic [ROWNUM_W-1:0]        row_number;
        logic                       row_end;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] blur0;
        logic signed [SAMPLE_W-1:0] blur1;
        logic signed [SAMPLE_W-1:0] blur2;
        logic signed [SAMPLE_W-1:0] blur3;
        logic [COL_W-1:0]           out_column;
        logic [ROWNUM_W-1:0]        out_row;
        logic                       row_done;
    } out_beat_t;

    typedef logic [BANK_N-1:0][BANK_W-1:0] wbank_t;

    // tap k weight, taps past 16 weigh zero
    function automatic logic [WEIGHT_W-1:0] tap_weight(input wbank_t banks,
                                                       input logic [WEIGHT_W-1:0] w16,
                                                       input int k);
        logic [WEIGHT_W-1:0] w;
        w = '0;
        if (k < 16)
            w = banks[k / 4][(k % 4) * WEIGHT_W +: WEIGHT_W];
        else if (k == 16)
            w = w16;
        return w;
    endfunction

    // round to nearest, ties up, then saturate to the sample range
    function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-17:0] q;
        logic signed [SAMPLE_W-1:0] res;
        sum = acc + ACC_W'(32768);
        q   = sum[ACC_W-1:16];
        if (q > $signed((ACC_W-16)'(23'h7FFFFF)))
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (q < -$signed((ACC_W-16)'(24'h800000)))
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            res = q[SAMPLE_W-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/sfrb_front.sv =====
// ----------------------------------------------------------------------------
// sfrb_front
// counts columns, finds the row end and the span of output columns per pixel
// ----------------------------------------------------------------------------
module sfrb_front #(
    parameter int MAX_RADIUS = sfrb_pkg::MAX_RADIUS_DEF,
    parameter int ROW_MAX    = sfrb_pkg::ROW_MAX_DEF,
    parameter int SW         = 10,
    parameter int RW         = 5,
    parameter int JOB_W      = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sfrb_pkg::in_beat_t            in_data,
    input  logic [sfrb_pkg::RADIUS_W-1:0] radius,
    input  logic                          zero_pad,
    output logic                          job_valid,
    input  logic                          job_ready,
    output logic [JOB_W-1:0]              job_data
);

    localparam int CNT_W = $clog2(ROW_MAX);

    logic [CNT_W-1:0]     col_reg, col_next;
    logic [CNT_W:0]       n_u;
    logic                 last;
    logic [RW-1:0]        r;
    logic signed [SW-1:0] column, n_s, first, stop, r_s;
    logic                 emit;
    logic                 take;

    assign n_u  = {1'b0, col_reg} + (CNT_W+1)'(1);
    assign last = in_data.row_end || (n_u >= (CNT_W+1)'(ROW_MAX));
    assign r    = ({1'b0, radius} > 6'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius);

    always_comb
    begin
        column = SW'(col_reg);
        n_s    = SW'(n_u);
        r_s    = SW'(r);
        emit   = 1'b1;
        if (zero_pad)
        begin
            first = column;
            stop  = last ? column + r_s + r_s : column;
        end
        else if (last)
        begin
            first = (column >= r_s) ? column - r_s : '0;
            stop  = column;
        end
        else
        begin
            first = column - r_s;
            stop  = first;
            emit  = (column >= r_s);
        end
    end

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign take      = in_valid && job_ready;
    assign job_data  = {in_data.chan3, in_data.chan2, in_data.chan1, in_data.chan0,
                        in_data.row_number, n_s, first, stop, emit, zero_pad,
                        r, last};

    assign col_next = last ? '0 : n_u[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else if (take)
            col_reg <= col_next;
    end

endmodule

// ===== rtl/sfrb_queue.sv =====
// ----------------------------------------------------------------------------
// sfrb_queue
// two-entry job queue between the front and the filter back end
// ----------------------------------------------------------------------------
module sfrb_queue #(
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    logic [1:0][DATA_W-1:0] mem_reg;
    logic                   wp_reg, rp_reg;
    logic [1:0]             cnt_reg;
    logic                   push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/sfrb_back.sv =====
// ----------------------------------------------------------------------------
// sfrb_back
// tap window, column sequencer and the filter pipeline with output register
// ----------------------------------------------------------------------------
module sfrb_back #(
    parameter int MAX_RADIUS = sfrb_pkg::MAX_RADIUS_DEF,
    parameter int CHANNELS   = sfrb_pkg::CHANNELS_DEF,
    parameter int SW         = 10,
    parameter int RW         = 5,
    parameter int JOB_W      = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  logic [JOB_W-1:0]              job_data,
    input  sfrb_pkg::wbank_t              wbank,
    input  logic [sfrb_pkg::WEIGHT_W-1:0] weight_16,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sfrb_pkg::out_beat_t           out_data
);

    localparam int WIN_LEN = 2 * MAX_RADIUS + 1;
    localparam int IW      = $clog2(WIN_LEN);
    localparam int NT      = MAX_RADIUS + 1;
    localparam int NG      = (NT + 3) / 4;
    localparam int PAIR_W  = sfrb_pkg::SAMPLE_W + 1;
    localparam int PROD_W  = PAIR_W + sfrb_pkg::WEIGHT_W + 1;

    typedef logic [WIN_LEN-1:0][sfrb_pkg::SAMPLE_W-1:0] win_t;

    typedef struct packed {
        logic [sfrb_pkg::COL_W-1:0]    column;
        logic [sfrb_pkg::ROWNUM_W-1:0] row;
        logic                          done;
    } meta_t;

    // job fields
    logic [sfrb_pkg::LANES-1:0][sfrb_pkg::SAMPLE_W-1:0] j_smp;
    logic [sfrb_pkg::ROWNUM_W-1:0]                      j_row;
    logic signed [SW-1:0]                               j_n, j_first, j_stop;
    logic                                               j_emit, j_ext, j_last;
    logic [RW-1:0]                                      j_r;

    assign {j_smp, j_row, j_n, j_first, j_stop, j_emit, j_ext, j_r, j_last} = job_data;

    logic                          cur_valid_reg;
    logic [sfrb_pkg::ROWNUM_W-1:0] cur_row_reg;
    logic signed [SW-1:0]          cur_n_reg, cur_stop_reg, p_reg;
    logic                          cur_emit_reg, cur_ext_reg, cur_last_reg;
    logic [RW-1:0]                 cur_r_reg;
    win_t                          win_reg [CHANNELS];

    logic en, issue, cur_done, load;

    assign en        = !out_valid || out_ready;
    assign issue     = cur_valid_reg && cur_emit_reg && en;
    assign cur_done  = cur_valid_reg && (!cur_emit_reg || (issue && p_reg == cur_stop_reg));
    assign job_ready = !cur_valid_reg || cur_done;
    assign load      = job_valid && job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_valid_reg <= 1'b0;
        else if (load)
            cur_valid_reg <= 1'b1;
        else if (cur_done)
            cur_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_row_reg  <= j_row;
            cur_n_reg    <= j_n;
            cur_stop_reg <= j_stop;
            cur_emit_reg <= j_emit;
            cur_ext_reg  <= j_ext;
            cur_last_reg <= j_last;
            cur_r_reg    <= j_r;
            p_reg        <= j_first;
        end
        else if (issue)
            p_reg <= p_reg + SW'(1);
    end

    // sample history, newest at index 0
    for (genvar l = 0; l < CHANNELS; l++)
    begin : g_win
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                win_reg[l] <= '0;
            else if (load)
                win_reg[l] <= {win_reg[l][WIN_LEN-2:0], j_smp[l]};
        end
    end

    function automatic logic signed [sfrb_pkg::SAMPLE_W-1:0] fetch(
        input logic signed [SW-1:0] idx,
        input logic signed [SW-1:0] n,
        input logic                 ext,
        input win_t                 w);
        logic signed [SW-1:0]                cl;
        logic signed [sfrb_pkg::SAMPLE_W-1:0] v;
        v = '0;
        if (idx < 0)
            cl = '0;
        else if (idx > n - SW'(1))
            cl = n - SW'(1);
        else
            cl = idx;
        if (!(ext && (idx < 0 || idx > n - SW'(1))) && cl < $signed(SW'(WIN_LEN)))
            v = w[cl[IW-1:0]];
        return v;
    endfunction

    // stage 1: window taps and mirrored pair sums
    logic signed [SW-1:0] d;
    logic                 s1_valid_reg;
    meta_t                s1_meta_reg;
    logic signed [PAIR_W-1:0] s1_pair_reg [CHANNELS][NT];
    logic signed [PAIR_W-1:0] pair_c [CHANNELS][NT];

    assign d = cur_n_reg - SW'(1) - (cur_ext_reg ? p_reg - SW'(cur_r_reg) : p_reg);

    always_comb
    begin
        for (int l = 0; l < CHANNELS; l++)
        begin
            pair_c[l][0] = PAIR_W'(fetch(d, cur_n_reg, cur_ext_reg, win_reg[l]));
            for (int k = 1; k < NT; k++)
            begin
                if (k <= int'(cur_r_reg))
                    pair_c[l][k] = PAIR_W'(fetch(d - SW'(k), cur_n_reg, cur_ext_reg,
                                                 win_reg[l]))
                                 + PAIR_W'(fetch(d + SW'(k), cur_n_reg, cur_ext_reg,
                                                 win_reg[l]));
                else
                    pair_c[l][k] = '0;
            end
        end
    end

    // stage 2 products, stage 3 group sums
    logic                     s2_valid_reg, s3_valid_reg;
    meta_t                    s2_meta_reg, s3_meta_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [CHANNELS][NT];
    logic signed [sfrb_pkg::ACC_W-1:0] s3_part_reg [CHANNELS][NG];
    logic signed [sfrb_pkg::ACC_W-1:0] part_c [CHANNELS][NG];
    logic signed [sfrb_pkg::ACC_W-1:0] total_c [CHANNELS];

    always_comb
    begin
        for (int l = 0; l < CHANNELS; l++)
        begin
            total_c[l] = '0;
            for (int g = 0; g < NG; g++)
            begin
                part_c[l][g] = '0;
                for (int j = 0; j < 4; j++)
                begin
                    if (g * 4 + j < NT)
                        part_c[l][g] = part_c[l][g]
                                     + sfrb_pkg::ACC_W'(s2_prod_reg[l][g * 4 + j]);
                end
                total_c[l] = total_c[l] + s3_part_reg[l][g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            out_valid    <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_meta_reg.column <= sfrb_pkg::COL_W'($unsigned(p_reg));
            s1_meta_reg.row    <= cur_row_reg;
            s1_meta_reg.done   <= cur_last_reg && (p_reg == cur_stop_reg);
            s2_meta_reg        <= s1_meta_reg;
            s3_meta_reg        <= s2_meta_reg;
            for (int l = 0; l < CHANNELS; l++)
            begin
                for (int k = 0; k < NT; k++)
                begin
                    s1_pair_reg[l][k] <= pair_c[l][k];
                    s2_prod_reg[l][k] <= s1_pair_reg[l][k]
                        * $signed({1'b0, sfrb_pkg::tap_weight(wbank, weight_16, k)});
                end
                for (int g = 0; g < NG; g++)
                    s3_part_reg[l][g] <= part_c[l][g];
            end
            out_data.out_column <= s3_meta_reg.column;
            out_data.out_row    <= s3_meta_reg.row;
            out_data.row_done   <= s3_meta_reg.done;
            out_data.blur0 <= sfrb_pkg::round_sat(total_c[0]);
            out_data.blur1 <= (CHANNELS > 1) ? sfrb_pkg::round_sat(total_c[(CHANNELS > 1) ? 1 : 0])
                                             : '0;
            out_data.blur2 <= (CHANNELS > 2) ? sfrb_pkg::round_sat(total_c[(CHANNELS > 2) ? 2 : 0])
                                             : '0;
            out_data.blur3 <= (CHANNELS > 3) ? sfrb_pkg::round_sat(total_c[(CHANNELS > 3) ? 3 : 0])
                                             : '0;
        end
    end

endmodule

// ===== rtl/symmetric_fir_row_blur.sv =====
// ----------------------------------------------------------------------------
// symmetric_fir_row_blur
// symmetric fir row filter over four-channel pixels, results tagged transposed
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_ready  | one pixel with row tag and end flag
//  out     | output    | out_valid / out_ready| one filtered pixel with column and row
//  cfg     | input     | cfg_write            | one register write, no wait
//
//  one pixel a cycle is taken while the job queue has room; a pixel yields
//  zero, one, or at a row end up to radius+1 (clamp) or 2*radius+1 (extend)
//  results, sent one a cycle by the back end column sequencer while the
//  output is not stalled; after a column issues, its result passes the
//  tap, multiply, group sum and final sum with rounding registers
//  reset clears the window, column count, queue and all valid flags
//  a stalled output freezes the whole filter pipeline; the queue then fills
//  and in_ready drops
// ----------------------------------------------------------------------------
module symmetric_fir_row_blur #(
    parameter int MAX_RADIUS = sfrb_pkg::MAX_RADIUS_DEF,
    parameter int ROW_MAX    = sfrb_pkg::ROW_MAX_DEF,
    parameter int CHANNELS   = sfrb_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sfrb_pkg::in_beat_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sfrb_pkg::out_beat_t            out_data,
    input  logic                           cfg_write,
    input  logic [sfrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfrb_pkg::BANK_W-1:0]    cfg_data
);

    // signed working width for column arithmetic, with room for mirrored offsets
    localparam int SW    = $clog2(ROW_MAX + 4 * MAX_RADIUS) + 2;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int JOB_W = sfrb_pkg::LANES * sfrb_pkg::SAMPLE_W + sfrb_pkg::ROWNUM_W
                         + 3 * SW + 3 + RW;

    logic [sfrb_pkg::RADIUS_W-1:0] radius_reg;
    logic                          extend_reg;
    sfrb_pkg::wbank_t              wbank_reg;
    logic [sfrb_pkg::WEIGHT_W-1:0] w16_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            extend_reg <= 1'b0;
            wbank_reg  <= {192'd0, 64'd65535};
            w16_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sfrb_pkg::REG_RADIUS:  radius_reg   <= cfg_data[sfrb_pkg::RADIUS_W-1:0];
                sfrb_pkg::REG_EXTEND:  extend_reg   <= cfg_data[0];
                sfrb_pkg::REG_W0_3:    wbank_reg[0] <= cfg_data;
                sfrb_pkg::REG_W4_7:    wbank_reg[1] <= cfg_data;
                sfrb_pkg::REG_W8_11:   wbank_reg[2] <= cfg_data;
                sfrb_pkg::REG_W12_15:  wbank_reg[3] <= cfg_data;
                sfrb_pkg::REG_W16:     w16_reg      <= cfg_data[sfrb_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // front to queue, queue to back
    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    logic [JOB_W-1:0] fq_data, qb_data;

    sfrb_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .ROW_MAX    (ROW_MAX),
        .SW         (SW),
        .RW         (RW),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .radius        (radius_reg),
        .zero_pad      (extend_reg),
        .job_valid     (fq_valid),
        .job_ready     (fq_ready),
        .job_data      (fq_data)
    );

    sfrb_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    sfrb_back #(
        .MAX_RADIUS (MAX_RADIUS),
        .CHANNELS   (CHANNELS),
        .SW         (SW),
        .RW         (RW),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .wbank     (wbank_reg),
        .weight_16 (w16_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
